// ===== design/iecq_pkg.sv =====
// Shared types, constants and the merge function of the input event coalescing queue.
`default_nettype none

package iecq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int LEVEL_W     = 5;
   localparam int TYPE_W      = 3;
   localparam int PAY_W       = 64;
   localparam int ENTRY_W     = TYPE_W + PAY_W;

   localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(QUEUE_DEPTH - 1);

   // Event types that can merge
   localparam logic [TYPE_W-1:0] EV_REL_MOVE = 3'd0;
   localparam logic [TYPE_W-1:0] EV_ABS_MOVE = 3'd1;
   localparam logic [TYPE_W-1:0] EV_VSCROLL  = 3'd4;
   localparam logic [TYPE_W-1:0] EV_HSCROLL  = 3'd5;

   // Request functions
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Result status codes
   localparam logic [1:0] STAT_PUSHED  = 2'd0;
   localparam logic [1:0] STAT_DROPPED = 2'd1;
   localparam logic [1:0] STAT_POPPED  = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

   // Pop sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_HEAD,
      SEQ_WALK
   } seq_state_type;

   typedef struct packed {
      logic             ok;
      logic [PAY_W-1:0] pay;
   } merge_res_type;

   // Fold src into dst for the given type; ok is low when no merge is possible.
   function automatic merge_res_type try_merge(input logic [TYPE_W-1:0] ev_type,
                                               input logic [PAY_W-1:0] dst,
                                               input logic [PAY_W-1:0] src);
      logic [16:0]   sum_a;
      logic [16:0]   sum_b;
      logic          ovf_a;
      logic          ovf_b;
      merge_res_type res;
      sum_a  = {dst[15], dst[15:0]} + {src[15], src[15:0]};
      sum_b  = {dst[31], dst[31:16]} + {src[31], src[31:16]};
      ovf_a  = sum_a[16] ^ sum_a[15];
      ovf_b  = sum_b[16] ^ sum_b[15];
      res.ok  = 1'b0;
      res.pay = dst;
      unique case (ev_type)
         EV_REL_MOVE: begin
            if (!ovf_a && !ovf_b) begin
               res.ok  = 1'b1;
               res.pay = {dst[63:32], sum_b[15:0], sum_a[15:0]};
            end
         end
         EV_ABS_MOVE: begin
            if (dst[47:32] == src[47:32] && dst[63:48] == src[63:48]) begin
               res.ok  = 1'b1;
               res.pay = src;
            end
         end
         EV_VSCROLL, EV_HSCROLL: begin
            if (!ovf_a) begin
               res.ok  = 1'b1;
               res.pay = {dst[63:16], sum_a[15:0]};
            end
         end
         default: res.ok = 1'b0;
      endcase
      return res;
   endfunction

   // Count to 5-bit result field, masked when the count is wider
   function automatic logic [LEVEL_W-1:0] to_level(input logic [CNT_W-1:0] cnt);
      return LEVEL_W'(32'(cnt));
   endfunction

endpackage

`default_nettype wire

// ===== design/iecq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module iecq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/input_event_coalescing_queue.sv =====
// Top level of the input event coalescing queue: pointers, pop sequencer and result register.
`default_nettype none

// A push, a dropped push and a pop on an empty queue each have their result
// in the result register in the cycle after acceptance. A pop reads the head
// and then examines up to QUEUE_DEPTH-1 entries after the head for merging:
// the events live in one RAM with a single registered read port, so the
// sequencer reads and folds one entry per cycle. One item is worked on at a
// time. A new item is taken only when the output register is empty, or when
// its result is taken in that same cycle, so a stalled result holds off the
// input.
module input_event_coalescing_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [iecq_pkg::TYPE_W-1:0]  req_event_type,
   input  wire logic [15:0]                  req_value_a,
   input  wire logic [15:0]                  req_value_b,
   input  wire logic [15:0]                  req_value_c,
   input  wire logic [15:0]                  req_value_d,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [iecq_pkg::TYPE_W-1:0]       rsp_event_type_res,
   output logic [15:0]                       rsp_value_a_res,
   output logic [15:0]                       rsp_value_b_res,
   output logic [15:0]                       rsp_value_c_res,
   output logic [15:0]                       rsp_value_d_res,
   output logic [iecq_pkg::LEVEL_W-1:0]      rsp_merged_count,
   output logic [iecq_pkg::LEVEL_W-1:0]      rsp_queue_level
);
   import iecq_pkg::*;

   seq_state_type      state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   merged_ff, merged_in;
   logic [TYPE_W-1:0]  acc_type_ff, acc_type_in;
   logic [PAY_W-1:0]   acc_pay_ff, acc_pay_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [TYPE_W-1:0]  rsp_type_ff, rsp_type_in;
   logic [PAY_W-1:0]   rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0]   rsp_merged_ff, rsp_merged_in;
   logic [CNT_W-1:0]   rsp_level_ff, rsp_level_in;

   logic               accept;
   logic [PTR_W-1:0]   head_next;
   logic [SUM_W-1:0]   tail_sum;
   logic [PTR_W-1:0]   tail;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [TYPE_W-1:0]  rd_type;
   logic [PAY_W-1:0]   rd_pay;
   merge_res_type      merge_res;

   logic               load;
   logic [1:0]         ld_status;
   logic [TYPE_W-1:0]  ld_type;
   logic [PAY_W-1:0]   ld_pay;
   logic [CNT_W-1:0]   ld_merged;
   logic [CNT_W-1:0]   ld_level;

   // Event store: type above the four words
   iecq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (wr_data),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign wr_data = {req_event_type, req_value_d, req_value_c, req_value_b, req_value_a};
   assign rd_type = rd_data[ENTRY_W-1:PAY_W];
   assign rd_pay  = rd_data[PAY_W-1:0];

   // Pointer arithmetic with wrap at the queue depth
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                              : PTR_W'(tail_sum);

   assign merge_res = try_merge(acc_type_ff, acc_pay_ff, rd_pay);

   // Take an item only when idle and the result slot is free or draining
   assign req_ready = (state_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Sequencer: next state, pointer updates and result load
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      merged_in   = merged_ff;
      acc_type_in = acc_type_ff;
      acc_pay_in  = acc_pay_ff;
      wr_en       = 1'b0;
      load        = 1'b0;
      ld_status   = STAT_EMPTY;
      ld_type     = '0;
      ld_pay      = '0;
      ld_merged   = '0;
      ld_level    = '0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_PUSH) begin
                  load = 1'b1;
                  if (count_ff == DEPTH_CNT) begin
                     ld_status = STAT_DROPPED;
                     ld_level  = count_ff;
                  end else begin
                     wr_en     = 1'b1;
                     count_in  = count_ff + 1'b1;
                     ld_status = STAT_PUSHED;
                     ld_level  = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  load      = 1'b1;
                  ld_status = STAT_EMPTY;
               end else begin
                  // head read issued at head_ff this cycle
                  state_in = SEQ_HEAD;
               end
            end
         end
         SEQ_HEAD: begin
            acc_type_in = rd_type;
            acc_pay_in  = rd_pay;
            head_in     = head_next;
            count_in    = count_ff - 1'b1;
            merged_in   = CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               load      = 1'b1;
               ld_status = STAT_POPPED;
               ld_type   = rd_type;
               ld_pay    = rd_pay;
               ld_merged = CNT_W'(1);
               ld_level  = '0;
               state_in  = SEQ_IDLE;
            end else begin
               state_in = SEQ_WALK;
            end
         end
         SEQ_WALK: begin
            if (rd_type == acc_type_ff && merge_res.ok) begin
               acc_pay_in = merge_res.pay;
               head_in    = head_next;
               count_in   = count_ff - 1'b1;
               merged_in  = merged_ff + 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  load      = 1'b1;
                  ld_status = STAT_POPPED;
                  ld_type   = acc_type_ff;
                  ld_pay    = merge_res.pay;
                  ld_merged = merged_ff + 1'b1;
                  ld_level  = '0;
                  state_in  = SEQ_IDLE;
               end
            end else begin
               load      = 1'b1;
               ld_status = STAT_POPPED;
               ld_type   = acc_type_ff;
               ld_pay    = acc_pay_ff;
               ld_merged = merged_ff;
               ld_level  = count_ff;
               state_in  = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Result register next values
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_type_in   = rsp_type_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_level_in  = rsp_level_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ld_status;
         rsp_type_in   = ld_type;
         rsp_pay_in    = ld_pay;
         rsp_merged_in = ld_merged;
         rsp_level_in  = ld_level;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      merged_ff     <= merged_in;
      acc_type_ff   <= acc_type_in;
      acc_pay_ff    <= acc_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_type_ff   <= rsp_type_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_event_type_res = rsp_type_ff;
   assign rsp_value_a_res    = rsp_pay_ff[15:0];
   assign rsp_value_b_res    = rsp_pay_ff[31:16];
   assign rsp_value_c_res    = rsp_pay_ff[47:32];
   assign rsp_value_d_res    = rsp_pay_ff[63:48];
   assign rsp_merged_count   = to_level(rsp_merged_ff);
   assign rsp_queue_level    = to_level(rsp_level_ff);

endmodule

`default_nettype wire
